>>> hw/rtl/vigenere_key_recovery_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef VIGENERE_KEY_RECOVERY_UNIT_DEFINES_SVH
`define VIGENERE_KEY_RECOVERY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define VKR_AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define VKR_AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/vkr_pkg.sv
// Package: constants, frequency tables and pipeline structs of the key recovery unit.
`default_nettype none
package vkr_pkg;

    localparam int MAX_KEY_DEF     = 16;
    localparam int COUNT_WIDTH_DEF = 20;
    localparam int ALPHA           = 26;
    localparam logic [7:0] LETTER_A = 8'd65;
    localparam logic [7:0] LETTER_Z = 8'd90;
    localparam logic [4:0] LAST_BIN = 5'd25;

    // One scoring term in flight.
    typedef struct packed {
        logic       vld;
        logic [4:0] idx_i;
        logic [4:0] shift_k;
        logic       last_i;
        logic       last_k;
    } t_term;

    // Column result from the scorer.
    typedef struct packed {
        logic       vld;
        logic [4:0] key;
    } t_best;

    // English letter frequency, Q0.16.
    function automatic logic [15:0] freq_q16(input logic [4:0] idx);
        logic [15:0] v;
        unique case (idx)
            5'd0:  v = 16'd5374;
            5'd1:  v = 16'd983;
            5'd2:  v = 16'd1835;
            5'd3:  v = 16'd2818;
            5'd4:  v = 16'd8520;
            5'd5:  v = 16'd1442;
            5'd6:  v = 16'd1311;
            5'd7:  v = 16'd3998;
            5'd8:  v = 16'd4588;
            5'd9:  v = 16'd98;
            5'd10: v = 16'd505;
            5'd11: v = 16'd2621;
            5'd12: v = 16'd1573;
            5'd13: v = 16'd4391;
            5'd14: v = 16'd4915;
            5'd15: v = 16'd1245;
            5'd16: v = 16'd62;
            5'd17: v = 16'd3932;
            5'd18: v = 16'd4129;
            5'd19: v = 16'd5964;
            5'd20: v = 16'd1835;
            5'd21: v = 16'd642;
            5'd22: v = 16'd1573;
            5'd23: v = 16'd98;
            5'd24: v = 16'd1311;
            5'd25: v = 16'd48;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Reciprocal frequency, Q11.5.
    function automatic logic [15:0] recip_q5(input logic [4:0] idx);
        logic [15:0] v;
        unique case (idx)
            5'd0:  v = 16'd390;
            5'd1:  v = 16'd2133;
            5'd2:  v = 16'd1143;
            5'd3:  v = 16'd744;
            5'd4:  v = 16'd246;
            5'd5:  v = 16'd1455;
            5'd6:  v = 16'd1600;
            5'd7:  v = 16'd525;
            5'd8:  v = 16'd457;
            5'd9:  v = 16'd21333;
            5'd10: v = 16'd4156;
            5'd11: v = 16'd800;
            5'd12: v = 16'd1333;
            5'd13: v = 16'd478;
            5'd14: v = 16'd427;
            5'd15: v = 16'd1684;
            5'd16: v = 16'd33684;
            5'd17: v = 16'd533;
            5'd18: v = 16'd508;
            5'd19: v = 16'd352;
            5'd20: v = 16'd1143;
            5'd21: v = 16'd3265;
            5'd22: v = 16'd1333;
            5'd23: v = 16'd21333;
            5'd24: v = 16'd1600;
            5'd25: v = 16'd43243;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/vkr_score.sv
// Shift scoring pipeline: deviation terms, saturating sum, best-shift select.
`default_nettype none
module vkr_score #(
    parameter int COUNT_WIDTH = vkr_pkg::COUNT_WIDTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  vkr_pkg::t_term        i_term,     // issue stage, same cycle as memory read
    input  wire [COUNT_WIDTH-1:0] i_total,    // column total, stable over the column
    input  wire [COUNT_WIDTH-1:0] i_rd_data,  // registered memory data, in the cycle after the read
    output vkr_pkg::t_best        o_best
);
    import vkr_pkg::*;

    localparam int DW = COUNT_WIDTH + 16;
    localparam int PW = DW + 16;

    t_term             r_t1, r_t2, r_t3;
    logic [DW-1:0]     r_b1;
    logic [DW-1:0]     r_d2;
    logic [PW-1:0]     r_p3;
    logic [63:0]       r_sum;
    logic [63:0]       r_best_sum;
    logic [4:0]        r_best_k;
    t_best             r_best;

    logic [DW-1:0]     a_val;
    logic [63:0]       acc_base;
    logic [64:0]       acc_wide;
    logic [63:0]       n_sum;
    logic              take_new;

    assign a_val    = {i_rd_data, 16'd0};
    assign acc_base = (r_t3.idx_i == 5'd0) ? 64'd0 : r_sum;
    assign acc_wide = {1'b0, acc_base} + 65'(r_p3);
    assign n_sum    = acc_wide[64] ? {64{1'b1}} : acc_wide[63:0];
    assign take_new = (r_t3.shift_k == 5'd0) || (n_sum < r_best_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1   <= '0;
            r_t2   <= '0;
            r_t3   <= '0;
            r_best <= '0;
        end else begin
            r_t1 <= i_term;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
            r_best.vld <= 1'b0;
            if (r_t3.vld) begin
                r_sum <= n_sum;
                if (r_t3.last_i && take_new) begin
                    r_best_sum <= n_sum;
                    r_best_k   <= r_t3.shift_k;
                end
                if (r_t3.last_i && r_t3.last_k) begin
                    r_best.vld <= 1'b1;
                    r_best.key <= take_new ? r_t3.shift_k : r_best_k;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_b1 <= DW'(freq_q16(i_term.idx_i) * i_total);
        r_d2 <= (a_val > r_b1) ? (a_val - r_b1) : (r_b1 - a_val);
        r_p3 <= PW'(r_d2 * recip_q5(r_t2.idx_i));
    end

    assign o_best = r_best;

endmodule
`default_nettype wire

>>> hw/rtl/vigenere_key_recovery_unit.sv
// Top level: Vigenere key recovery by per-column letter histograms and shift scoring.
// Intake: a letter beat reads its count, then writes it back; other bytes need no write-back.
// On end of text each column issues its 26 shifts x 26 bins terms, then drains the
// 4-stage scorer; a column starts only once the previous key letter is taken.
// After reset and after every message a clearing pass over all MAX_KEY*26 entries zeroes
// the count memory; no beat is accepted meanwhile. Config writes are taken any time.
`default_nettype none
module vigenere_key_recovery_unit #(
    parameter int MAX_KEY     = vkr_pkg::MAX_KEY_DEF,
    parameter int COUNT_WIDTH = vkr_pkg::COUNT_WIDTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // configuration
    input  wire        i_key_length_we,
    input  wire [4:0]  i_key_length,
    // ciphertext channel
    input  wire        i_valid,
    output logic       o_stall,
    input  wire [7:0]  i_text_char,
    input  wire        i_end_of_text,
    // key letter channel
    output logic       o_valid,
    input  wire        i_stall,
    output logic [4:0] o_key_letter,
    output logic [3:0] o_key_position,
    output logic       o_last_key
);
    import vkr_pkg::*;

    localparam int DEPTH = MAX_KEY * ALPHA;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;  // column index
    localparam int LW    = $clog2(MAX_KEY + 1);                  // period value
    localparam int EW    = ((LW > CW) ? LW : CW) + 1;            // compare width
    localparam logic [AW-1:0] ALPHA_A = AW'(ALPHA);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,   // sweeping zeros through the count memory
        S_IDLE,    // taking ciphertext beats
        S_WR,      // writing back an incremented bin
        S_NEXT,    // waiting for the output register before a new column
        S_SCORE,   // issuing the 26x26 terms of one column
        S_WAIT     // draining the scorer
    } t_state;

    t_state                 r_state;
    logic [4:0]             r_key_length;
    logic [CW-1:0]          r_ptr;
    logic                   r_ptr_eot;
    logic [COUNT_WIDTH-1:0] r_totals [MAX_KEY];
    logic [AW-1:0]          r_clr_addr;
    logic [AW-1:0]          r_wr_addr;
    logic [CW-1:0]          r_sc_col;
    logic [4:0]             r_i;
    logic [4:0]             r_k;
    logic                   r_o_valid;
    logic [4:0]             r_key_letter;
    logic [3:0]             r_key_position;
    logic                   r_last_key;

    // count memory, registered read
    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [COUNT_WIDTH-1:0] mem_wd;
    logic [AW-1:0]          mem_ra;

    logic [LW-1:0]          len;
    logic [CW-1:0]          col;
    logic [EW-1:0]          col_inc;
    logic                   in_acc;
    logic                   is_letter;
    logic [4:0]             bin;
    logic [AW-1:0]          in_addr;
    logic [5:0]             rot_sum;
    logic [4:0]             rot_idx;
    logic [AW-1:0]          sc_addr;
    logic                   out_take;
    logic                   sc_last_col;
    t_term                  term;
    t_best                  best;

    // effective period: zero acts as one, clipped at MAX_KEY
    always_comb begin
        if (r_key_length == 5'd0) begin
            len = LW'(1);
        end else if (8'(r_key_length) > 8'(MAX_KEY)) begin
            len = LW'(MAX_KEY);
        end else begin
            len = LW'(r_key_length);
        end
    end

    // a pointer left beyond a shrunk period falls back to column 0
    assign col       = (EW'(r_ptr) >= EW'(len)) ? '0 : r_ptr;
    assign col_inc   = EW'(col) + EW'(1);
    assign in_acc    = i_valid && !o_stall;
    assign is_letter = (i_text_char >= LETTER_A) && (i_text_char <= LETTER_Z);
    assign bin       = 5'(i_text_char - LETTER_A);
    assign in_addr   = AW'(col) * ALPHA_A + AW'(bin);

    // bin (i + k) mod 26
    assign rot_sum = 6'(r_i) + 6'(r_k);
    assign rot_idx = (rot_sum >= 6'(ALPHA)) ? 5'(rot_sum - 6'(ALPHA)) : rot_sum[4:0];
    assign sc_addr = AW'(r_sc_col) * ALPHA_A + AW'(rot_idx);

    assign sc_last_col = (EW'(r_sc_col) + EW'(1)) == EW'(len);
    assign out_take    = r_o_valid && !i_stall;

    assign mem_ra = (r_state == S_SCORE) ? sc_addr : in_addr;
    assign mem_we = (r_state == S_CLEAR) || (r_state == S_WR);
    assign mem_wa = (r_state == S_CLEAR) ? r_clr_addr : r_wr_addr;
    assign mem_wd = (r_state == S_CLEAR) ? '0 :
                    ((r_rd_data == {COUNT_WIDTH{1'b1}}) ? r_rd_data : r_rd_data + 1'b1);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    always_comb begin
        term         = '0;
        term.vld     = (r_state == S_SCORE);
        term.idx_i   = r_i;
        term.shift_k = r_k;
        term.last_i  = (r_i == LAST_BIN);
        term.last_k  = (r_k == LAST_BIN);
    end

    vkr_score #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_score (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_term    (term),
        .i_total   (r_totals[r_sc_col]),
        .i_rd_data (r_rd_data),
        .o_best    (best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_key_length <= 5'd1;
            r_ptr        <= '0;
            r_clr_addr   <= '0;
            r_sc_col     <= '0;
            r_i          <= '0;
            r_k          <= '0;
            r_o_valid    <= 1'b0;
            for (int c = 0; c < MAX_KEY; c++) begin
                r_totals[c] <= '0;
            end
        end else begin
            if (i_key_length_we) begin
                r_key_length <= i_key_length;
            end

            // result register: filled by the scorer, emptied by the taker
            if (best.vld) begin
                r_o_valid      <= 1'b1;
                r_key_letter   <= best.key;
                r_key_position <= 4'(r_sc_col);
                r_last_key     <= sc_last_col;
            end else if (out_take) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_A) begin
                        r_clr_addr <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_ptr     <= (col_inc >= EW'(len)) ? '0 : CW'(col_inc);
                        r_wr_addr <= in_addr;
                        r_sc_col  <= '0;
                        if (is_letter && (r_totals[col] != {COUNT_WIDTH{1'b1}})) begin
                            r_totals[col] <= r_totals[col] + 1'b1;
                        end
                        if (is_letter) begin
                            r_state <= S_WR;
                        end else if (i_end_of_text) begin
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_WR: begin
                    // scoring follows the write if this was the last beat
                    r_state <= (r_sc_col == '0 && r_ptr_eot) ? S_NEXT : S_IDLE;
                end
                S_NEXT: begin
                    if (!r_o_valid) begin
                        r_i     <= '0;
                        r_k     <= '0;
                        r_state <= S_SCORE;
                    end
                end
                S_SCORE: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == LAST_BIN) begin
                        r_i <= '0;
                        r_k <= r_k + 1'b1;
                        if (r_k == LAST_BIN) begin
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (best.vld) begin
                        if (sc_last_col) begin
                            r_ptr   <= '0;
                            r_state <= S_CLEAR;
                            for (int c = 0; c < MAX_KEY; c++) begin
                                r_totals[c] <= '0;
                            end
                        end else begin
                            r_sc_col <= r_sc_col + 1'b1;
                            r_state  <= S_NEXT;
                        end
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // end-of-text flag held across the write-back cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr_eot <= 1'b0;
        end else if (in_acc) begin
            r_ptr_eot <= i_end_of_text;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_key_letter   = r_key_letter;
    assign o_key_position = r_key_position;
    assign o_last_key     = r_last_key;

endmodule
`default_nettype wire

>>> hw/rtl/vkr_checker.sv
// Port-level checker for the key recovery unit, with its bind.
`default_nettype none
`include "vigenere_key_recovery_unit_defines.svh"
module vkr_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       o_stall,
    input wire       i_end_of_text,
    input wire       o_valid,
    input wire       i_stall,
    input wire [4:0] o_key_letter,
    input wire [3:0] o_key_position,
    input wire       o_last_key
);
    `VKR_AST_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `VKR_AST_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_key_letter) && $stable(o_key_position) && $stable(o_last_key))
    `VKR_AST_SAME(a_letter_range, i_clk, i_rst_n, o_valid, o_key_letter < 5'd26)
    `VKR_AST_NEXT(a_eot_busy, i_clk, i_rst_n, i_valid && !o_stall && i_end_of_text, o_stall)
endmodule

bind vigenere_key_recovery_unit vkr_checker u_vkr_checker (.*);
`default_nettype wire
